// ----- hdl/rcs_pkg.sv -----
// rcs_pkg: shared constants, types and helper functions for the rotating cookie store
// used by rcs_div and rotating_cookie_store; no dependencies
`timescale 1ns / 1ps

package rcs_pkg;

    // slot row size and derived widths
    localparam int SLOTS = 8;
    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // field widths
    localparam int TIME_W      = 32;
    localparam int COOKIE_W    = 64;
    localparam int ROOM_W      = 8;
    localparam int LEN_W       = 4;
    localparam int RI_W        = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CNT_W:0]   cntx_t;
    typedef logic [COOKIE_W-1:0] cookie_t;
    typedef logic [LEN_W-1:0] len_t;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_SECS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_COOKIE_LENGTH = 1'b1;

    // reset values of the registers
    localparam logic [RI_W-1:0]  RESET_PERIOD_SECS   = 16'd60;
    localparam logic [LEN_W-1:0] RESET_COOKIE_LENGTH = 4'd8;

    // opcodes
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_VERIFY   = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TIME_BACK = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM   = 2'd2;
    localparam logic [1:0] STATUS_ZERO_RAND = 2'd3;

    // effective cookie length, clamped to 1..8 bytes
    function automatic len_t eff_len(input len_t cl);
        len_t r;
        if (cl == len_t'(0))
            r = len_t'(1);
        else if (cl > len_t'(8))
            r = len_t'(8);
        else
            r = cl;
        return r;
    endfunction

    // mask covering the low len bytes
    function automatic cookie_t byte_mask(input len_t len);
        cookie_t m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (len_t'(b) < len)
                m[8*b +: 8] = 8'hff;
        end
        return m;
    endfunction

    // next slot pointer, wrapping at the row size
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(SLOTS - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

    // pointer moved back by s slots, modulo the row size
    function automatic ptr_t ptr_sub(input ptr_t p, input cnt_t s);
        cntx_t pe;
        cntx_t se;
        ptr_t  r;
        pe = cntx_t'(p);
        se = (s == cnt_t'(SLOTS)) ? '0 : cntx_t'(s);
        if (pe >= se)
            r = ptr_t'(pe - se);
        else
            r = ptr_t'(pe + cntx_t'(SLOTS) - se);
        return r;
    endfunction

endpackage

// ----- hdl/rcs_div.sv -----
// rcs_div: two 32-bit by 16-bit restoring dividers sharing one divisor, one bit per cycle
// depends on rcs_pkg
`timescale 1ns / 1ps

module rcs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rcs_pkg::TIME_W-1:0]    num_a,
    input  logic [rcs_pkg::TIME_W-1:0]    num_b,
    input  logic [rcs_pkg::RI_W-1:0]      divisor,
    output logic                          done,
    output logic [rcs_pkg::TIME_W-1:0]    quo_a,
    output logic [rcs_pkg::TIME_W-1:0]    quo_b
);

    localparam int STEP_W = $clog2(rcs_pkg::TIME_W);

    logic [rcs_pkg::TIME_W-1:0] a_reg;
    logic [rcs_pkg::TIME_W-1:0] b_reg;
    logic [rcs_pkg::RI_W-1:0]   rem_a_reg;
    logic [rcs_pkg::RI_W-1:0]   rem_b_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [rcs_pkg::RI_W:0]     trial_a;
    logic [rcs_pkg::RI_W:0]     trial_b;
    logic [rcs_pkg::RI_W:0]     dext;
    logic                       ge_a;
    logic                       ge_b;
    logic [rcs_pkg::RI_W-1:0]   rem_a_next;
    logic [rcs_pkg::RI_W-1:0]   rem_b_next;

    // one restoring step for each dividend
    always_comb
    begin
        dext       = {1'b0, divisor};
        trial_a    = {rem_a_reg, a_reg[rcs_pkg::TIME_W-1]};
        trial_b    = {rem_b_reg, b_reg[rcs_pkg::TIME_W-1]};
        ge_a       = (trial_a >= dext);
        ge_b       = (trial_b >= dext);
        rem_a_next = ge_a ? rcs_pkg::RI_W'(trial_a - dext) : trial_a[rcs_pkg::RI_W-1:0];
        rem_b_next = ge_b ? rcs_pkg::RI_W'(trial_b - dext) : trial_b[rcs_pkg::RI_W-1:0];
    end

    // iteration registers; dividends shift out as quotient bits shift in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg     <= num_a;
                b_reg     <= num_b;
                rem_a_reg <= '0;
                rem_b_reg <= '0;
                step_reg  <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                a_reg     <= {a_reg[rcs_pkg::TIME_W-2:0], ge_a};
                b_reg     <= {b_reg[rcs_pkg::TIME_W-2:0], ge_b};
                rem_a_reg <= rem_a_next;
                rem_b_reg <= rem_b_next;
                step_reg  <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(rcs_pkg::TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign quo_a = a_reg;
    assign quo_b = b_reg;

endmodule

// ----- hdl/rotating_cookie_store.sv -----
// rotating_cookie_store: top level with slot memory, control sequencer and result register
// depends on rcs_pkg and rcs_div
`timescale 1ns / 1ps

// Keeps a row of cookie slots, newest first, in a small synchronous memory addressed
// through a rotating head pointer, so aging the row by k periods moves the pointer and
// clears k slots instead of copying entries. One word is taken at a time. For a generate,
// the period count comes from a bit-serial divider that divides the new and the last
// generate time by the refresh period, then the aged slots are zeroed one per cycle through
// the single write port, then the newest slot is read and filled if it is empty. A generate
// rejected for room or for time going backwards skips the divider and goes straight to the
// result. A verify reads the slots one per cycle through the read port and compares each as
// it arrives; when the presented length is wrong it skips the reads. A new word is taken
// while the previous result still waits in the output register. Memory contents need no
// clearing after reset: only slots in use are ever looked at, and those are always written
// first.

module rotating_cookie_store (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [rcs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_seconds[31:0], random_value[95:32], cookie_in[159:96], cookie_in_length[167:160]
    input  logic [rcs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic [rcs_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cookie_out[63:0], cookie_out_length[67:64], match[68], zero[71:69]
    output logic [rcs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [rcs_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLEAR,
        ST_GRD,
        ST_GCHK,
        ST_VRD,
        ST_VLAST,
        ST_DONE
    } state_t;

    // configuration registers
    logic [rcs_pkg::RI_W-1:0]   period_secs_reg;
    logic [rcs_pkg::LEN_W-1:0]  cookie_length_reg;

    // control and item registers
    state_t                     state_reg;
    rcs_pkg::ptr_t              head_reg;
    rcs_pkg::ptr_t              walk_ptr_reg;
    rcs_pkg::cnt_t              used_reg;
    rcs_pkg::cnt_t              clr_cnt_reg;
    rcs_pkg::cnt_t              idx_reg;
    rcs_pkg::cnt_t              cmp_idx_reg;
    logic                       cmp_valid_reg;
    logic [rcs_pkg::TIME_W-1:0] last_gen_reg;
    logic [rcs_pkg::TIME_W-1:0] now_reg;
    rcs_pkg::cookie_t           random_reg;
    rcs_pkg::cookie_t           cookie_in_reg;
    logic                       div_start_reg;

    // result being built and the output register
    logic [1:0]                 res_status_reg;
    rcs_pkg::cookie_t           res_cookie_reg;
    rcs_pkg::len_t              res_len_reg;
    logic                       res_match_reg;
    logic                       m_valid_reg;
    logic [rcs_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic [rcs_pkg::OUT_TUSER_W-1:0] m_user_reg;

    // slot memory
    rcs_pkg::cookie_t           slot_mem [rcs_pkg::SLOTS];
    rcs_pkg::cookie_t           rd_data_reg;
    logic                       rd_en;
    rcs_pkg::ptr_t              rd_addr;
    logic                       wr_en;
    rcs_pkg::ptr_t              wr_addr;
    rcs_pkg::cookie_t           wr_data;

    // word fields
    logic                       in_op;
    logic [rcs_pkg::TIME_W-1:0] in_now;
    rcs_pkg::cookie_t           in_random;
    rcs_pkg::cookie_t           in_cookie;
    logic [rcs_pkg::ROOM_W-1:0] in_room;

    // derived values
    rcs_pkg::len_t              len;
    rcs_pkg::cookie_t           mask;
    rcs_pkg::cookie_t           slot_m;
    rcs_pkg::cookie_t           fresh;
    rcs_pkg::cookie_t           want;
    logic                       cmp_hit;
    logic                       fill_ok;
    logic [rcs_pkg::RI_W-1:0]   divisor;
    logic                       div_done;
    logic [rcs_pkg::TIME_W-1:0] q_now;
    logic [rcs_pkg::TIME_W-1:0] q_last;
    logic [rcs_pkg::TIME_W-1:0] q_diff;
    rcs_pkg::cnt_t              shift;
    rcs_pkg::cntx_t             used_sum;
    rcs_pkg::cnt_t              used_new;
    rcs_pkg::ptr_t              head_new;
    logic                       out_free;

    // unpack the request word
    assign in_op     = s_axis_tuser[0];
    assign in_now    = s_axis_tdata[31:0];
    assign in_random = s_axis_tdata[95:32];
    assign in_cookie = s_axis_tdata[159:96];
    assign in_room   = s_axis_tdata[167:160];

    // cookie length, masks and compares
    assign len     = rcs_pkg::eff_len(cookie_length_reg);
    assign mask    = rcs_pkg::byte_mask(len);
    assign slot_m  = rd_data_reg & mask;
    assign fresh   = random_reg & mask;
    assign want    = cookie_in_reg & mask;
    assign cmp_hit = cmp_valid_reg && (cmp_idx_reg < used_reg) &&
                     (slot_m != '0) && (slot_m == want);
    assign fill_ok = (state_reg == ST_GCHK) && (used_reg != '0) &&
                     (slot_m == '0) && (fresh != '0);

    // period count between the last generate and now
    assign divisor  = (period_secs_reg == '0) ? rcs_pkg::RI_W'(1) : period_secs_reg;
    assign q_diff   = q_now - q_last;
    assign shift    = (q_diff > rcs_pkg::TIME_W'(rcs_pkg::SLOTS)) ?
                      rcs_pkg::cnt_t'(rcs_pkg::SLOTS) : rcs_pkg::cnt_t'(q_diff);
    assign used_sum = rcs_pkg::cntx_t'(used_reg) + rcs_pkg::cntx_t'(shift);
    assign used_new = (used_sum > rcs_pkg::cntx_t'(rcs_pkg::SLOTS)) ?
                      rcs_pkg::cnt_t'(rcs_pkg::SLOTS) : rcs_pkg::cnt_t'(used_sum);
    assign head_new = rcs_pkg::ptr_sub(head_reg, shift);

    assign out_free = !m_valid_reg || m_axis_tready;

    rcs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .num_a   (now_reg),
        .num_b   (last_gen_reg),
        .divisor (divisor),
        .done    (div_done),
        .quo_a   (q_now),
        .quo_b   (q_last)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_secs_reg   <= rcs_pkg::RESET_PERIOD_SECS;
            cookie_length_reg <= rcs_pkg::RESET_COOKIE_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rcs_pkg::REG_PERIOD_SECS:   period_secs_reg <= cfg_wdata;
                rcs_pkg::REG_COOKIE_LENGTH: cookie_length_reg <= cfg_wdata[rcs_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = '0;
        unique case (state_reg)
            ST_GRD:
            begin
                rd_en = 1'b1;
            end
            ST_VRD:
            begin
                rd_en   = 1'b1;
                rd_addr = walk_ptr_reg;
            end
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = walk_ptr_reg;
            end
            ST_GCHK:
            begin
                wr_en   = fill_ok;
                wr_data = fresh;
            end
            default: ;
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= slot_mem[rd_addr];
    end

    // sequencer with result and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            walk_ptr_reg   <= '0;
            used_reg       <= '0;
            clr_cnt_reg    <= '0;
            idx_reg        <= '0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            last_gen_reg   <= '0;
            now_reg        <= '0;
            random_reg     <= '0;
            cookie_in_reg  <= '0;
            div_start_reg  <= 1'b0;
            res_status_reg <= rcs_pkg::STATUS_OK;
            res_cookie_reg <= '0;
            res_len_reg    <= '0;
            res_match_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            // drain the output word; the done state reloads it itself
            if (m_axis_tready && (state_reg != ST_DONE))
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    cmp_valid_reg <= 1'b0;
                    if (s_axis_tvalid)
                    begin
                        now_reg        <= in_now;
                        random_reg     <= in_random;
                        cookie_in_reg  <= in_cookie;
                        res_status_reg <= rcs_pkg::STATUS_OK;
                        res_cookie_reg <= '0;
                        res_len_reg    <= '0;
                        res_match_reg  <= 1'b0;
                        if (in_op == rcs_pkg::OP_GENERATE)
                        begin
                            priority if (in_room < rcs_pkg::ROOM_W'(len))
                            begin
                                res_status_reg <= rcs_pkg::STATUS_NO_ROOM;
                                state_reg      <= ST_DONE;
                            end
                            else if (in_now < last_gen_reg)
                            begin
                                res_status_reg <= rcs_pkg::STATUS_TIME_BACK;
                                state_reg      <= ST_DONE;
                            end
                            else
                            begin
                                div_start_reg <= 1'b1;
                                state_reg     <= ST_DIV;
                            end
                        end
                        else if (in_room == rcs_pkg::ROOM_W'(len))
                        begin
                            walk_ptr_reg <= head_reg;
                            idx_reg      <= '0;
                            state_reg    <= ST_VRD;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end

                // age the row by the elapsed periods
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        head_reg     <= head_new;
                        used_reg     <= used_new;
                        last_gen_reg <= now_reg;
                        walk_ptr_reg <= head_new;
                        clr_cnt_reg  <= shift;
                        state_reg    <= (shift != '0) ? ST_CLEAR : ST_GRD;
                    end
                end

                // zero the slots that entered at the new end
                ST_CLEAR:
                begin
                    walk_ptr_reg <= rcs_pkg::ptr_inc(walk_ptr_reg);
                    clr_cnt_reg  <= clr_cnt_reg - rcs_pkg::cnt_t'(1);
                    if (clr_cnt_reg == rcs_pkg::cnt_t'(1))
                        state_reg <= ST_GRD;
                end

                ST_GRD:
                begin
                    state_reg <= ST_GCHK;
                end

                // return the newest slot in use, filling it first if it is empty
                ST_GCHK:
                begin
                    res_len_reg <= len;
                    priority if (used_reg == '0)
                        res_cookie_reg <= '0;
                    else if (slot_m != '0)
                        res_cookie_reg <= slot_m;
                    else if (fresh == '0)
                    begin
                        res_status_reg <= rcs_pkg::STATUS_ZERO_RAND;
                        res_cookie_reg <= '0;
                        res_len_reg    <= '0;
                    end
                    else
                        res_cookie_reg <= fresh;
                    state_reg <= ST_DONE;
                end

                // read one slot a cycle, compare the one that came back
                ST_VRD:
                begin
                    walk_ptr_reg  <= rcs_pkg::ptr_inc(walk_ptr_reg);
                    idx_reg       <= idx_reg + rcs_pkg::cnt_t'(1);
                    cmp_valid_reg <= 1'b1;
                    cmp_idx_reg   <= idx_reg;
                    if (cmp_hit)
                        res_match_reg <= 1'b1;
                    if (idx_reg == rcs_pkg::cnt_t'(rcs_pkg::SLOTS - 1))
                        state_reg <= ST_VLAST;
                end

                ST_VLAST:
                begin
                    cmp_valid_reg <= 1'b0;
                    if (cmp_hit)
                        res_match_reg <= 1'b1;
                    state_reg <= ST_DONE;
                end

                // hand the result to the output register
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, res_match_reg, res_len_reg, res_cookie_reg};
                        m_user_reg  <= res_status_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // used slot count never exceeds the row
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= rcs_pkg::cnt_t'(rcs_pkg::SLOTS))
        else $error("used slot count out of range");

    // head pointer stays inside the row
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= rcs_pkg::ptr_t'(rcs_pkg::SLOTS - 1))
        else $error("head pointer out of range");

    // the sequencer never reads and writes the memory in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory read and write in the same cycle");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide wait");

    // last generate time moves only when a period count completes
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg == ST_DIV) && div_done) |=> $stable(last_gen_reg))
        else $error("last generate time changed unexpectedly");

endmodule
